@@ hdl/sttk_pkg.sv @@
package sttk_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int LABEL_BYTES = 8;

   localparam int KEY_W   = 31;
   localparam int WAVE_W  = 16;
   localparam int MAP_W   = 8;
   localparam int STAMP_W = 32;
   localparam int LABEL_W = 64;
   localparam int READ_W  = 4;
   localparam int PLACE_W = 4;
   localparam int FILL_W  = 5;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int SEL_W = (IDX_W > READ_W) ? IDX_W : READ_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int Q_IDX_W     = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_READ   = 1'b1
   } op_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [WAVE_W-1:0]  wave;
      logic [MAP_W-1:0]   map;
      logic [STAMP_W-1:0] stamp;
      logic [LABEL_W-1:0] label;
   } entry_type;

   typedef struct packed {
      op_type            op;
      entry_type         rec;
      logic [READ_W-1:0] index;
   } cmd_type;

   // name stops at its first zero byte; only the low LABEL_BYTES survive
   function automatic logic [LABEL_W-1:0] clean_label(input logic [LABEL_W-1:0] raw);
      logic [LABEL_W-1:0] kept;
      logic               live;
      kept = '0;
      live = 1'b1;
      for (int b = 0; b < LABEL_W / 8; b++) begin
         live = live && (raw[8*b +: 8] != 8'd0) && (b < LABEL_BYTES);
         if (live) begin
            kept[8*b +: 8] = raw[8*b +: 8];
         end
      end
      return kept;
   endfunction

endpackage

@@ hdl/sttk_if.sv @@
interface sttk_req_if
   import sttk_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic                operation;
   logic [KEY_W-1:0]    new_key;
   logic [WAVE_W-1:0]   new_wave;
   logic [MAP_W-1:0]    new_map;
   logic [STAMP_W-1:0]  new_stamp;
   logic [LABEL_W-1:0]  new_label;
   logic [READ_W-1:0]   read_index;

   modport source (output valid, operation, new_key, new_wave, new_map, new_stamp,
                   new_label, read_index, input ready);
   modport sink   (input valid, operation, new_key, new_wave, new_map, new_stamp,
                   new_label, read_index, output ready);
endinterface

interface sttk_rsp_if
   import sttk_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic                placed;
   logic [PLACE_W-1:0]  place_index;
   logic [KEY_W-1:0]    out_key;
   logic [WAVE_W-1:0]   out_wave;
   logic [MAP_W-1:0]    out_map;
   logic [STAMP_W-1:0]  out_stamp;
   logic [LABEL_W-1:0]  out_label;
   logic [FILL_W-1:0]   filled_count;

   modport source (output valid, placed, place_index, out_key, out_wave, out_map,
                   out_stamp, out_label, filled_count, input ready);
   modport sink   (input valid, placed, place_index, out_key, out_wave, out_map,
                   out_stamp, out_label, filled_count, output ready);
endinterface

@@ hdl/sttk_front.sv @@
module sttk_front
   import sttk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   sttk_req_if.sink    req_ch,
   output logic        cmd_valid,
   input  logic        cmd_ready,
   output cmd_type     cmd
);

   cmd_type              q_ff [QUEUE_DEPTH];
   logic [Q_IDX_W-1:0]   wr_ff, wr_in;
   logic [Q_IDX_W-1:0]   rd_ff, rd_in;
   logic [Q_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                 push, pop;
   cmd_type              incoming;

   always_comb begin
      incoming.op          = op_type'(req_ch.operation);
      incoming.rec.key     = req_ch.new_key;
      incoming.rec.wave    = req_ch.new_wave;
      incoming.rec.map     = req_ch.new_map;
      incoming.rec.stamp   = req_ch.new_stamp;
      incoming.rec.label   = clean_label(req_ch.new_label);
      incoming.index       = req_ch.read_index;

      req_ch.ready = (cnt_ff != Q_CNT_W'(QUEUE_DEPTH));
      cmd_valid    = (cnt_ff != '0);
      cmd          = q_ff[rd_ff];
      push         = req_ch.valid && req_ch.ready;
      pop          = cmd_valid && cmd_ready;

      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) begin
         wr_in = (wr_ff == Q_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == Q_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      cnt_in = cnt_ff + Q_CNT_W'(push) - Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= incoming;
      end
   end

endmodule

@@ hdl/sttk_back.sv @@
module sttk_back
   import sttk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd,
   sttk_rsp_if.source  rsp_ch
);

   entry_type           table_ff [TABLE_DEPTH];
   entry_type           table_in [TABLE_DEPTH];
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                valid_ff, valid_in;
   logic                placed_ff, placed_in;
   logic [PLACE_W-1:0]  place_ff, place_in;
   entry_type           read_ff, read_in;

   logic [TABLE_DEPTH-1:0] hit;
   logic [IDX_W-1:0]       mark;
   logic                   take, ins, in_range;
   logic [SEL_W-1:0]       sel;
   logic [IDX_W-1:0]       rd_idx;

   always_comb begin
      take = cmd_valid && (!valid_ff || rsp_ch.ready);
      cmd_ready = take;
      ins  = take && (cmd.op == OP_INSERT);

      // table stays sorted, so hits form a suffix; first hit is the slot
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         hit[i] = (table_ff[i].key <= cmd.rec.key);
      end
      mark = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (hit[i]) begin
            mark = IDX_W'(i);
         end
      end

      for (int i = 0; i < TABLE_DEPTH; i++) begin
         table_in[i] = table_ff[i];
         if (ins && hit[i]) begin
            if (i == 0) begin
               table_in[i] = cmd.rec;
            end else if (!hit[i-1]) begin
               table_in[i] = cmd.rec;
            end else begin
               table_in[i] = table_ff[i-1];
            end
         end
      end

      cnt_in = cnt_ff;
      if (ins && hit[TABLE_DEPTH-1] && (cmd.rec.key != '0) &&
          (cnt_ff != CNT_W'(TABLE_DEPTH))) begin
         cnt_in = cnt_ff + 1'b1;
      end

      sel      = SEL_W'(cmd.index);
      rd_idx   = sel[IDX_W-1:0];
      in_range = (32'(cmd.index) < TABLE_DEPTH);

      valid_in  = valid_ff;
      placed_in = placed_ff;
      place_in  = place_ff;
      read_in   = read_ff;
      if (take) begin
         valid_in  = 1'b1;
         placed_in = ins && hit[TABLE_DEPTH-1];
         place_in  = (ins && hit[TABLE_DEPTH-1]) ? PLACE_W'(mark) : '0;
         read_in   = (!ins && in_range) ? table_ff[rd_idx] : '0;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end

      rsp_ch.valid        = valid_ff;
      rsp_ch.placed       = placed_ff;
      rsp_ch.place_index  = place_ff;
      rsp_ch.out_key      = read_ff.key;
      rsp_ch.out_wave     = read_ff.wave;
      rsp_ch.out_map      = read_ff.map;
      rsp_ch.out_stamp    = read_ff.stamp;
      rsp_ch.out_label    = read_ff.label;
      rsp_ch.filled_count = FILL_W'(cnt_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            table_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            table_ff[i] <= table_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      placed_ff <= placed_in;
      place_ff  <= place_in;
      read_ff   <= read_in;
   end

endmodule

@@ hdl/sorted_top_k_record_table.sv @@
// Sorted table of 16 records (key, wave, map, stamp, 8-byte name), highest key
// first, cleared by reset. Insert places a record ahead of the first entry whose
// key is less than or equal to its own and drops the last entry; read returns one
// entry. Every item yields one result, which also carries the count of nonzero
// keys. Items pass through a two-entry queue into a table of cells that all compare
// and shift together, so one item per cycle is sustained while results are taken; an
// accepted item is written into the queue, then moved into the result registers, where
// its result is presented, and a result not yet taken holds the next items in the queue.
module sorted_top_k_record_table
   import sttk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   sttk_req_if.sink    req_ch,
   sttk_rsp_if.source  rsp_ch
);

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   sttk_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   sttk_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_ch    (rsp_ch)
   );

endmodule

@@ sim/tb.sv @@
module tb;
   import sttk_pkg::*;

   typedef struct {
      logic               placed;
      logic [PLACE_W-1:0] place_index;
      entry_type          rec;
      logic [FILL_W-1:0]  filled;
   } table_answer;

   class record_table_scoreboard;
      entry_type   rows[TABLE_DEPTH];
      table_answer awaited[$];
      int          errors;

      function new();
         foreach (rows[i]) rows[i] = '0;
         errors = 0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      task report(string what);
         errors++;
         if (errors <= 50) begin
            $display("mismatch: %s", what);
         end
      endtask

      function logic [LABEL_W-1:0] trim_label(logic [LABEL_W-1:0] raw);
         logic [LABEL_W-1:0] kept;
         int                 b;
         kept = '0;
         b = 0;
         while (b < LABEL_BYTES && b < LABEL_W / 8 && raw[8*b +: 8] != 8'h00) begin
            kept[8*b +: 8] = raw[8*b +: 8];
            b++;
         end
         return kept;
      endfunction

      function void note_request(cmd_type c);
         table_answer a;
         int          mark;
         int          n;
         a.placed      = 1'b0;
         a.place_index = '0;
         a.rec         = '0;
         mark          = TABLE_DEPTH;
         if (c.op == OP_INSERT) begin
            // lowest position whose key does not exceed the new one; ties go first
            for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
               if (rows[i].key <= c.rec.key) mark = i;
            end
            if (mark < TABLE_DEPTH) begin
               for (int i = TABLE_DEPTH - 1; i > mark; i--) rows[i] = rows[i-1];
               rows[mark]       = c.rec;
               rows[mark].label = trim_label(c.rec.label);
               a.placed         = 1'b1;
               a.place_index    = PLACE_W'(mark);
            end
         end else if (c.index < TABLE_DEPTH) begin
            a.rec = rows[c.index];
         end
         n = 0;
         foreach (rows[i]) if (rows[i].key != '0) n++;
         a.filled = FILL_W'(n);
         awaited.push_back(a);
      endfunction

      task compare(string field, logic [63:0] got, logic [63:0] want);
         if (got !== want) begin
            report($sformatf("%s got %0h expected %0h", field, got, want));
         end
      endtask

      task check_result(table_answer got);
         table_answer want;
         if (awaited.size() == 0) begin
            report("result with no item outstanding");
            return;
         end
         want = awaited.pop_front();
         compare("placed", got.placed, want.placed);
         compare("place_index", got.place_index, want.place_index);
         compare("out_key", got.rec.key, want.rec.key);
         compare("out_wave", got.rec.wave, want.rec.wave);
         compare("out_map", got.rec.map, want.rec.map);
         compare("out_stamp", got.rec.stamp, want.rec.stamp);
         compare("out_label", got.rec.label, want.rec.label);
         compare("filled_count", got.filled, want.filled);
      endtask
   endclass

   logic clock;
   logic reset;
   int   stall_pct = 18;

   record_table_scoreboard sb;

   sttk_req_if req_ch();
   sttk_rsp_if rsp_ch();

   sorted_top_k_record_table dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic cmd_type make_cmd(op_type op, logic [KEY_W-1:0] key,
                                        logic [WAVE_W-1:0] wave, logic [MAP_W-1:0] map,
                                        logic [STAMP_W-1:0] stamp,
                                        logic [LABEL_W-1:0] label,
                                        logic [READ_W-1:0] index);
      cmd_type c;
      c.op        = op;
      c.rec.key   = key;
      c.rec.wave  = wave;
      c.rec.map   = map;
      c.rec.stamp = stamp;
      c.rec.label = label;
      c.index     = index;
      return c;
   endfunction

   // keys mostly land next to entries already held, so the table stays full and churns
   function automatic cmd_type random_item();
      cmd_type          c;
      int               pick;
      logic [KEY_W-1:0] near;
      c.op        = ($urandom_range(0, 99) < 35) ? OP_READ : OP_INSERT;
      c.rec.wave  = WAVE_W'($urandom());
      c.rec.map   = MAP_W'($urandom());
      c.rec.stamp = $urandom();
      c.rec.label = {$urandom(), $urandom()};
      c.index     = READ_W'($urandom());
      pick = $urandom_range(0, 99);
      near = sb.rows[$urandom_range(0, TABLE_DEPTH - 1)].key;
      if (pick < 55 && near != '1) begin
         case ($urandom_range(0, 2))
            0: begin
               c.rec.key = (near == '0) ? near : near - 1'b1;
            end
            1: begin
               c.rec.key = near;
            end
            default: begin
               c.rec.key = near + 1'b1;
            end
         endcase
      end else if (pick < 65) begin
         c.rec.key = '0;
      end else if (pick < 66) begin
         c.rec.key = '1;
      end else if (pick < 78) begin
         c.rec.key = KEY_W'($urandom_range(0, 15));
      end else begin
         c.rec.key = KEY_W'($urandom());
      end
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
         c.rec.label[8*$urandom_range(0, 7) +: 8] = 8'h00;
      end else if (pick == 3) begin
         c.rec.label = '0;
      end else if (pick == 4) begin
         c.rec.label = c.rec.label & ((64'd1 << (8 * $urandom_range(1, 7))) - 64'd1);
      end
      return c;
   endfunction

   task automatic send_item(cmd_type c);
      while ($urandom_range(0, 99) < stall_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.operation  <= c.op;
      req_ch.new_key    <= c.rec.key;
      req_ch.new_wave   <= c.rec.wave;
      req_ch.new_map    <= c.rec.map;
      req_ch.new_stamp  <= c.rec.stamp;
      req_ch.new_label  <= c.rec.label;
      req_ch.read_index <= c.index;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic hold_until_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cmd_type seen;
      if (!reset && req_ch.valid && req_ch.ready) begin
         seen.op        = op_type'(req_ch.operation);
         seen.rec.key   = req_ch.new_key;
         seen.rec.wave  = req_ch.new_wave;
         seen.rec.map   = req_ch.new_map;
         seen.rec.stamp = req_ch.new_stamp;
         seen.rec.label = req_ch.new_label;
         seen.index     = req_ch.read_index;
         sb.note_request(seen);
      end
   end

   always @(posedge clock) begin
      table_answer got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.placed      = rsp_ch.placed;
         got.place_index = rsp_ch.place_index;
         got.rec.key     = rsp_ch.out_key;
         got.rec.wave    = rsp_ch.out_wave;
         got.rec.map     = rsp_ch.out_map;
         got.rec.stamp   = rsp_ch.out_stamp;
         got.rec.label   = rsp_ch.out_label;
         got.filled      = rsp_ch.filled_count;
         sb.check_result(got);
      end
   end

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < 2000) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      sb = new();
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.operation  <= OP_INSERT;
      req_ch.new_key    <= '0;
      req_ch.new_wave   <= '0;
      req_ch.new_map    <= '0;
      req_ch.new_stamp  <= '0;
      req_ch.new_label  <= '0;
      req_ch.read_index <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty table reads
      send_item(make_cmd(OP_READ, '1, '1, '1, '1, '1, 4'd0));
      send_item(make_cmd(OP_READ, '0, '0, '0, '0, '0, 4'd15));
      // zero key still qualifies against an empty slot
      send_item(make_cmd(OP_INSERT, '0, 16'h1234, 8'h56, 32'h0, 64'h0, 4'd0));
      send_item(make_cmd(OP_INSERT, '1, '1, '1, '1, '1, 4'd0));
      // tie on the top key, name cut at the embedded zero byte
      send_item(make_cmd(OP_INSERT, '1, 16'h0, 8'h0, 32'h1, 64'h4847_4600_4443_4241, 4'd0));
      // name starting with a zero byte stores as empty
      send_item(make_cmd(OP_INSERT, 31'd1, 16'h8000, 8'h80, 32'h8000_0000,
                         64'h6867_6665_6463_6200, 4'd0));
      send_item(make_cmd(OP_INSERT, 31'd1000, 16'h00ff, 8'h0f, 32'hdead_beef,
                         64'h0807_0605_0403_0201, 4'd0));
      send_item(make_cmd(OP_READ, '0, '0, '0, '0, '0, 4'd0));
      send_item(make_cmd(OP_READ, '0, '0, '0, '0, '0, 4'd3));
      // fill the table and push the zero-key entry out
      for (int i = 0; i < 12; i++) begin
         send_item(make_cmd(OP_INSERT, KEY_W'(5000 + 97 * i), WAVE_W'($urandom()),
                            MAP_W'($urandom()), $urandom(), {$urandom(), $urandom()},
                            4'd0));
      end
      // full table: zero key is refused, key equal to the last entry lands last
      send_item(make_cmd(OP_INSERT, '0, 16'h5555, 8'haa, 32'h1234_5678, 64'h41, 4'd0));
      send_item(make_cmd(OP_INSERT, 31'd1, 16'haaaa, 8'h55, 32'h8765_4321, 64'h4242, 4'd0));
      send_item(make_cmd(OP_READ, '0, '0, '0, '0, '0, 4'd15));
      hold_until_drained();

      for (int n = 0; n < 1300; n++) begin
         stall_pct = (n >= 400 && n < 650) ? 0 : 18;
         if (n == 800) begin
            hold_until_drained();
         end
         send_item(random_item());
      end

      hold_until_drained();
      repeat (10) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.report("results still outstanding at end of run");
      end
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
